[rtl/ibrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ibrc_pkg;

  // Sample and coefficient formats.
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;

  // Gyro minus bias needs one more bit than a raw sample.
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int PROD_BITS   = COEF_BITS + DIFF_BITS;
  localparam int SUM_BITS    = PROD_BITS + 2;
  localparam int SCALED_BITS = SUM_BITS - COEF_FRAC_BITS;

  localparam int GYRO_OUT_BITS  = SAMPLE_BITS + 2;
  localparam int ACCEL_OUT_BITS = SAMPLE_BITS + 1;

  localparam int BIAS_BITS = 3 * SAMPLE_BITS;
  localparam int ROW_BITS  = 3 * COEF_BITS;
  localparam int CFG_BITS  = ROW_BITS;
  localparam int IDX_BITS  = 32;

  typedef enum logic [1:0] {
    CFG_GYRO_BIAS = 2'd0,
    CFG_ROW_0     = 2'd1,
    CFG_ROW_1     = 2'd2,
    CFG_ROW_2     = 2'd3
  } cfg_reg_t;

  typedef logic signed [DIFF_BITS-1:0]      diff_t;
  typedef logic signed [SCALED_BITS-1:0]    scaled_t;
  typedef logic signed [GYRO_OUT_BITS-1:0]  gyro_out_t;
  typedef logic signed [ACCEL_OUT_BITS-1:0] accel_out_t;

  // Per-stage load enables shared by the lanes and the merge stage.
  typedef struct packed {
    logic prod;
    logic sum;
    logic out;
  } stage_en_t;

  localparam gyro_out_t  GYRO_HI  = {1'b0, {(GYRO_OUT_BITS-1){1'b1}}};
  localparam gyro_out_t  GYRO_LO  = {1'b1, {(GYRO_OUT_BITS-1){1'b0}}};
  localparam accel_out_t ACCEL_HI = {1'b0, {(ACCEL_OUT_BITS-1){1'b1}}};
  localparam accel_out_t ACCEL_LO = {1'b1, {(ACCEL_OUT_BITS-1){1'b0}}};

endpackage

`default_nettype wire

[rtl/ibrc_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

// One matrix row times one vector: three products, then the sum scaled
// down with truncation toward zero.
module ibrc_lane (
  input  wire logic                        clk,
  input  wire ibrc_pkg::stage_en_t         en,
  input  wire logic [ibrc_pkg::ROW_BITS-1:0] coef_row,
  input  wire ibrc_pkg::diff_t             vec [3],
  output      ibrc_pkg::scaled_t           scaled_r
);
  import ibrc_pkg::*;

  logic signed [PROD_BITS-1:0] prod_r [3];
  logic signed [COEF_BITS-1:0] coef   [3];
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [SUM_BITS-1:0]  round_adj;
  logic signed [SUM_BITS-1:0]  sum_adj;
  scaled_t                     scaled_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coef[j] = $signed(coef_row[j*COEF_BITS +: COEF_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[j] <= coef[j] * vec[j];
      end
    end
  end

  // A negative sum gets 2^F - 1 added before the arithmetic shift so the
  // quotient rounds toward zero.
  always_comb begin
    sum = SUM_BITS'(prod_r[0]) + SUM_BITS'(prod_r[1]) + SUM_BITS'(prod_r[2]);
    round_adj = $signed({{(SUM_BITS-COEF_FRAC_BITS){1'b0}},
                         {COEF_FRAC_BITS{sum[SUM_BITS-1]}}});
    sum_adj = sum + round_adj;
    scaled_nxt = SCALED_BITS'(sum_adj >>> COEF_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      scaled_r <= scaled_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/ibrc_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

// Saturates the six lane results to their output widths and folds the
// clip indications into one flag. Holds the output word.
module ibrc_merge (
  input  wire logic                          clk,
  input  wire ibrc_pkg::stage_en_t           en,
  input  wire ibrc_pkg::scaled_t             gyro_scaled  [3],
  input  wire ibrc_pkg::scaled_t             accel_scaled [3],
  input  wire logic [ibrc_pkg::IDX_BITS-1:0] idx,
  output      logic [ibrc_pkg::IDX_BITS-1:0] idx_r,
  output      ibrc_pkg::gyro_out_t           gyro_r  [3],
  output      ibrc_pkg::accel_out_t          accel_r [3],
  output      logic                          clipped_r
);
  import ibrc_pkg::*;

  gyro_out_t  gyro_nxt  [3];
  accel_out_t accel_nxt [3];
  logic       clipped_nxt;

  always_comb begin
    clipped_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (gyro_scaled[i] > SCALED_BITS'(GYRO_HI)) begin
        gyro_nxt[i] = GYRO_HI;
        clipped_nxt = 1'b1;
      end else if (gyro_scaled[i] < SCALED_BITS'(GYRO_LO)) begin
        gyro_nxt[i] = GYRO_LO;
        clipped_nxt = 1'b1;
      end else begin
        gyro_nxt[i] = GYRO_OUT_BITS'(gyro_scaled[i]);
      end
      if (accel_scaled[i] > SCALED_BITS'(ACCEL_HI)) begin
        accel_nxt[i] = ACCEL_HI;
        clipped_nxt = 1'b1;
      end else if (accel_scaled[i] < SCALED_BITS'(ACCEL_LO)) begin
        accel_nxt[i] = ACCEL_LO;
        clipped_nxt = 1'b1;
      end else begin
        accel_nxt[i] = ACCEL_OUT_BITS'(accel_scaled[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.out) begin
      idx_r     <= idx;
      gyro_r    <= gyro_nxt;
      accel_r   <= accel_nxt;
      clipped_r <= clipped_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/imu_bias_rotation_corrector_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Word
// in_       input      in_valid/stall    six signed 16-bit raw axes
// out_      output     out_valid/stall   sample index, six rotated axes, clip flag
// cfg_      input      cfg_wr_en         register index and 54-bit data
//
// One word is accepted per clock while in_stall is low; the pipeline is four
// stages deep. Stages: input capture with bias subtraction, nine-plus-nine
// multipliers in six row lanes, row sum with scaling, then saturation into
// the output word. Each stage holds its word only while the stage after it
// is full and blocked, so bubbles close up and in_stall rises only when all
// four are full. Reset (rst_n low, synchronous) empties the pipeline, clears
// the sample count and the gyro bias, and loads the identity rotation.
module imu_bias_rotation_corrector_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic signed [ibrc_pkg::SAMPLE_BITS-1:0] in_gyro_x,
  input  wire logic signed [ibrc_pkg::SAMPLE_BITS-1:0] in_gyro_y,
  input  wire logic signed [ibrc_pkg::SAMPLE_BITS-1:0] in_gyro_z,
  input  wire logic signed [ibrc_pkg::SAMPLE_BITS-1:0] in_accel_x,
  input  wire logic signed [ibrc_pkg::SAMPLE_BITS-1:0] in_accel_y,
  input  wire logic signed [ibrc_pkg::SAMPLE_BITS-1:0] in_accel_z,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic [ibrc_pkg::IDX_BITS-1:0]      out_sample_index,
  output      ibrc_pkg::gyro_out_t                out_gyro_out_x,
  output      ibrc_pkg::gyro_out_t                out_gyro_out_y,
  output      ibrc_pkg::gyro_out_t                out_gyro_out_z,
  output      ibrc_pkg::accel_out_t               out_accel_out_x,
  output      ibrc_pkg::accel_out_t               out_accel_out_y,
  output      ibrc_pkg::accel_out_t               out_accel_out_z,
  output      logic                               out_clipped,
  input  wire logic                               cfg_wr_en,
  input  wire ibrc_pkg::cfg_reg_t                 cfg_index,
  input  wire logic [ibrc_pkg::CFG_BITS-1:0]      cfg_data
);
  import ibrc_pkg::*;

  // Configuration registers. The identity matrix has 1.0 on the diagonal.
  logic [BIAS_BITS-1:0] bias_r;
  logic [ROW_BITS-1:0]  row_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r   <= '0;
      row_r[0] <= ROW_BITS'(1) << COEF_FRAC_BITS;
      row_r[1] <= ROW_BITS'(1) << (COEF_FRAC_BITS + COEF_BITS);
      row_r[2] <= ROW_BITS'(1) << (COEF_FRAC_BITS + 2 * COEF_BITS);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GYRO_BIAS: bias_r   <= cfg_data[BIAS_BITS-1:0];
        CFG_ROW_0:     row_r[0] <= cfg_data[ROW_BITS-1:0];
        CFG_ROW_1:     row_r[1] <= cfg_data[ROW_BITS-1:0];
        CFG_ROW_2:     row_r[2] <= cfg_data[ROW_BITS-1:0];
      endcase
    end
  end

  // Stage occupancy and the ready chain running back from the output.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc;
  stage_en_t en;

  assign rdy4   = !v4_r || !out_stall;
  assign rdy3   = !v3_r || rdy4;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign in_acc = in_valid && rdy1;

  assign en.prod = rdy2;
  assign en.sum  = rdy3;
  assign en.out  = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // The sample count stamps each word as it is accepted.
  logic [IDX_BITS-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= cnt_r + IDX_BITS'(1);
    end
  end

  // Stage 1: bias subtraction. Accel axes are sign-extended to the same
  // width so all six lanes are identical.
  logic signed [SAMPLE_BITS-1:0] gyro_in [3];
  logic signed [SAMPLE_BITS-1:0] accel_in [3];
  diff_t gyro_diff_r  [3];
  diff_t accel_ext_r  [3];
  logic [IDX_BITS-1:0] idx1_r, idx2_r, idx3_r;

  assign gyro_in[0]  = in_gyro_x;
  assign gyro_in[1]  = in_gyro_y;
  assign gyro_in[2]  = in_gyro_z;
  assign accel_in[0] = in_accel_x;
  assign accel_in[1] = in_accel_y;
  assign accel_in[2] = in_accel_z;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 3; i++) begin
        gyro_diff_r[i] <= DIFF_BITS'(gyro_in[i])
                        - DIFF_BITS'($signed(bias_r[i*SAMPLE_BITS +: SAMPLE_BITS]));
        accel_ext_r[i] <= DIFF_BITS'(accel_in[i]);
      end
      idx1_r <= cnt_r;
    end
  end

  // The index rides alongside the lanes' product and sum stages.
  always_ff @(posedge clk) begin
    if (rdy2) idx2_r <= idx1_r;
    if (rdy3) idx3_r <= idx2_r;
  end

  // Six row lanes: three for the gyro vector, three for the accel vector.
  scaled_t gyro_scaled  [3];
  scaled_t accel_scaled [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    ibrc_lane u_gyro_lane (
      .clk      (clk),
      .en       (en),
      .coef_row (row_r[r]),
      .vec      (gyro_diff_r),
      .scaled_r (gyro_scaled[r])
    );
    ibrc_lane u_accel_lane (
      .clk      (clk),
      .en       (en),
      .coef_row (row_r[r]),
      .vec      (accel_ext_r),
      .scaled_r (accel_scaled[r])
    );
  end

  // Stage 4: saturation and the output word.
  gyro_out_t  gyro_o  [3];
  accel_out_t accel_o [3];

  ibrc_merge u_merge (
    .clk          (clk),
    .en           (en),
    .gyro_scaled  (gyro_scaled),
    .accel_scaled (accel_scaled),
    .idx          (idx3_r),
    .idx_r        (out_sample_index),
    .gyro_r       (gyro_o),
    .accel_r      (accel_o),
    .clipped_r    (out_clipped)
  );

  assign in_stall        = !rdy1;
  assign out_valid       = v4_r;
  assign out_gyro_out_x  = gyro_o[0];
  assign out_gyro_out_y  = gyro_o[1];
  assign out_gyro_out_z  = gyro_o[2];
  assign out_accel_out_x = accel_o[0];
  assign out_accel_out_y = accel_o[1];
  assign out_accel_out_z = accel_o[2];

endmodule

`default_nettype wire

[rtl/ibrc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ibrc_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [ibrc_pkg::IDX_BITS-1:0]      out_sample_index,
  input wire ibrc_pkg::gyro_out_t                out_gyro_out_x,
  input wire ibrc_pkg::gyro_out_t                out_gyro_out_y,
  input wire ibrc_pkg::gyro_out_t                out_gyro_out_z,
  input wire ibrc_pkg::accel_out_t               out_accel_out_x,
  input wire ibrc_pkg::accel_out_t               out_accel_out_y,
  input wire ibrc_pkg::accel_out_t               out_accel_out_z,
  input wire logic                               out_clipped
);
  import ibrc_pkg::*;

  // Index the next delivered word should carry.
  logic [IDX_BITS-1:0] exp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_valid && !out_stall) begin
      exp_idx_r <= exp_idx_r + IDX_BITS'(1);
    end
  end

  // The pipeline is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Words come out in order, none lost or repeated.
  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_index == exp_idx_r)
    else $error("sample index out of sequence");

  // A clipped word has at least one axis sitting on a limit.
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_gyro_out_x == GYRO_HI || out_gyro_out_x == GYRO_LO ||
       out_gyro_out_y == GYRO_HI || out_gyro_out_y == GYRO_LO ||
       out_gyro_out_z == GYRO_HI || out_gyro_out_z == GYRO_LO ||
       out_accel_out_x == ACCEL_HI || out_accel_out_x == ACCEL_LO ||
       out_accel_out_y == ACCEL_HI || out_accel_out_y == ACCEL_LO ||
       out_accel_out_z == ACCEL_HI || out_accel_out_z == ACCEL_LO))
    else $error("clip flag without a saturated axis");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_sample_index) && $stable(out_clipped) &&
       $stable(out_gyro_out_x) && $stable(out_gyro_out_y) &&
       $stable(out_gyro_out_z) && $stable(out_accel_out_x) &&
       $stable(out_accel_out_y) && $stable(out_accel_out_z)))
    else $error("stalled output word changed");

  // The input only stalls when a waiting result is held off.
  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output could move");

endmodule

bind imu_bias_rotation_corrector_top ibrc_checker u_ibrc_checker (.*);

`default_nettype wire
